// ===== rtl/core/ctp_pkg.sv =====
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared types and constants for the cubic trajectory player.
// ----------------------------------------------------------------------------
`default_nettype none

package ctp_pkg;

   // Default geometry of the curve table
   localparam int SEGMENTS_DEF = 5;
   localparam int POINTS_DEF   = 2;

   localparam int AXES  = 3;
   localparam int TERMS = 4;

   // Field widths
   localparam int COEF_W    = 32;
   localparam int X_W       = 16;
   localparam int ELAPSED_W = 16;
   localparam int INTERV_W  = 10;
   localparam int LIMIT_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [1:0]           AXIS_COUNT  = 2'd3;
   localparam logic [1:0]           TERM_CUBE   = 2'd3;
   localparam logic [1:0]           TERM_SQUARE = 2'd2;
   localparam logic [1:0]           TERM_CONST  = 2'd0;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

   // Register reset values
   localparam logic [INTERV_W-1:0] FIRE_INTERVAL_RESET = 10'd40;
   localparam logic [LIMIT_W-1:0]  HYPERFRAME_RESET    = 16'd400;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRE_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HYPERFRAME    = 2'd1;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_START = 2'd1,
      FUNC_TICK  = 2'd2
   } func_type;

   // Control of the shared multiply-add unit
   typedef struct packed {
      logic load;   // acc <= coefficient
      logic mul;    // product <= acc * x
      logic add;    // acc <= sat(product >> 16 + coefficient)
   } mac_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/core/ctp_ram.sv =====
// ----------------------------------------------------------------------------
// ctp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_ram #(
   parameter  int WIDTH = 32,
   parameter  int DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ctp_coef_store.sv =====
// ----------------------------------------------------------------------------
// ctp_coef_store
// Coefficient table: RAM plus one valid bit per word; unwritten words read 0.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_coef_store
   import ctp_pkg::*;
#(
   parameter  int SEGMENTS = SEGMENTS_DEF,
   localparam int DEPTH    = AXES * SEGMENTS * TERMS,
   localparam int AW       = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [COEF_W-1:0] wr_data,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [COEF_W-1:0] rd_data
);

   logic [DEPTH-1:0]  valid_ff;
   logic              rd_valid_ff;
   logic [COEF_W-1:0] ram_q;

   ctp_ram #(
      .WIDTH (COEF_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? ram_q : '0;

endmodule

`default_nettype wire

// ===== rtl/core/ctp_mac.sv =====
// ----------------------------------------------------------------------------
// ctp_mac
// Shared Horner step: registered Q16.16 x Q0.16 product, then saturating add.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_mac
   import ctp_pkg::*;
(
   input  wire logic                     clock,
   input  wire mac_ctrl_type             ctrl,
   input  wire logic signed [COEF_W-1:0] coef,
   input  wire logic        [X_W-1:0]    x,
   output logic signed      [COEF_W-1:0] add_result
);

   localparam int PROD_W = COEF_W + X_W + 1;
   localparam int SHR_W  = PROD_W - X_W;
   localparam int SUM_W  = SHR_W + 1;

   logic signed [COEF_W-1:0] acc_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SHR_W-1:0]  shifted;
   logic signed [SUM_W-1:0]  sum;

   // floor(product / 2^16) is the arithmetic shift
   assign shifted = $signed(prod_ff[PROD_W-1:X_W]);
   assign sum     = SUM_W'(shifted) + SUM_W'(coef);

   always_comb begin
      if (sum[SUM_W-1:COEF_W-1] == '0 || sum[SUM_W-1:COEF_W-1] == '1) begin
         add_result = sum[COEF_W-1:0];
      end else if (sum[SUM_W-1]) begin
         add_result = {1'b1, {(COEF_W-1){1'b0}}};
      end else begin
         add_result = {1'b0, {(COEF_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         acc_ff <= coef;
      end else if (ctrl.add) begin
         acc_ff <= add_result;
      end
      if (ctrl.mul) begin
         prod_ff <= acc_ff * $signed({1'b0, x});
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cubic_trajectory_player.sv =====
// ----------------------------------------------------------------------------
// cubic_trajectory_player
// Timer-driven playback of a three-axis piecewise-cubic trajectory.
// ----------------------------------------------------------------------------
// Usage
//  - Items enter on req_* and are taken when start is high and busy low.
//    req_func selects: coefficient write, start playback, or 1 ms tick.
//  - A coefficient write or a start completes in the accepting cycle; busy
//    stays low. A tick while stopped also just advances the elapsed time.
//  - A tick while playing raises busy for the due-time compare. If
//    no fire is due, busy drops again after that compare.
//  - A fire evaluates roll, pitch and yaw one after another on the shared
//    multiply-add unit: per axis one table fetch, one load and three
//    multiply/add pairs. rsp_valid strobes after the last yaw add, and
//    busy falls in the same cycle. The table RAM's registered read and
//    the single multiplier set this sequence.
//  - Results appear for one cycle only; the receiver has no back-pressure.
//  - csr_* writes the fire interval and hyperframe limit; csr_ready is
//    always high. Write them only while busy is low.
//  - Reset clears the table (per-word valid bits, no clearing pass), stops
//    playback and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_trajectory_player
   import ctp_pkg::*;
#(
   parameter int SEGMENTS = SEGMENTS_DEF,
   parameter int POINTS   = POINTS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // item channel
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [1:0]           req_func,
   input  wire logic [1:0]           req_axis,
   input  wire logic [2:0]           req_segment,
   input  wire logic [1:0]           req_term,
   input  wire logic signed [COEF_W-1:0] req_coefficient,
   // result channel
   output logic                      rsp_valid,
   output logic signed [COEF_W-1:0]  rsp_roll_angle,
   output logic signed [COEF_W-1:0]  rsp_pitch_angle,
   output logic signed [COEF_W-1:0]  rsp_yaw_angle,
   output logic [3:0]                rsp_fire_number,
   output logic                      rsp_last_fire,
   // register channel
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data
);

   localparam int TOTAL   = SEGMENTS * POINTS;
   localparam int FIRE_W  = $clog2(TOTAL + 1);
   localparam int POINT_W = (POINTS > 1) ? $clog2(POINTS) : 1;
   localparam int SEG_W   = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int ROW_W   = $clog2(AXES * SEGMENTS);
   localparam int ADDR_W  = ROW_W + 2;
   localparam int DUE_W   = FIRE_W + INTERV_W;
   localparam int CMP_W   = (DUE_W > ELAPSED_W) ? DUE_W : ELAPSED_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FETCH,
      ST_LOAD,
      ST_MUL,
      ST_ADD
   } state_type;

   // Sample points x = floor(r * 2^16 / POINTS), fixed at elaboration
   logic [X_W-1:0] x_lut [2**POINT_W];

   for (genvar r = 0; r < 2**POINT_W; r++) begin : g_xlut
      localparam logic [X_W-1:0] XV = (r < POINTS) ? X_W'((r * 65536) / POINTS) : '0;
      assign x_lut[r] = XV;
   end

   state_type                state_ff, state_in;
   logic                     playing_ff, playing_in;
   logic [ELAPSED_W-1:0]     elapsed_ff, elapsed_in;
   logic [FIRE_W-1:0]        next_fire_ff, next_fire_in;
   logic [POINT_W-1:0]       point_ff, point_in;
   logic [SEG_W-1:0]         seg_ff, seg_in;
   logic [1:0]               axis_ff, axis_in;
   logic [1:0]               term_ff, term_in;
   logic [INTERV_W-1:0]      interval_ff, interval_in;
   logic [LIMIT_W-1:0]       limit_ff, limit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [COEF_W-1:0] roll_ff, roll_in;
   logic signed [COEF_W-1:0] pitch_ff, pitch_in;
   logic signed [COEF_W-1:0] yaw_ff, yaw_in;
   logic [3:0]               fire_num_ff, fire_num_in;
   logic                     last_ff, last_in;

   logic                     accept;
   logic                     wr_en;
   logic                     wr_ok;
   logic [ROW_W-1:0]         wr_row;
   logic [ROW_W-1:0]         rd_row;
   logic [ADDR_W-1:0]        wr_addr;
   logic [ADDR_W-1:0]        rd_addr;
   logic [COEF_W-1:0]        coef_q;
   logic signed [COEF_W-1:0] mac_result;
   mac_ctrl_type             mac_ctrl;
   logic [CMP_W-1:0]         due;
   logic                     fire_due;
   logic [FIRE_W-1:0]        fire_inc;
   logic [FIRE_W+3:0]        fire_ext;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // coefficient write addressing: {axis * SEGMENTS + segment, term}
   assign wr_ok   = (req_axis < AXIS_COUNT) && (5'(req_segment) < 5'(SEGMENTS));
   assign wr_en   = accept && (req_func == FUNC_WRITE) && wr_ok;
   assign wr_row  = ROW_W'(int'(req_axis) * SEGMENTS + int'(req_segment));
   assign wr_addr = {wr_row, req_term};
   assign rd_row  = ROW_W'(int'(axis_ff) * SEGMENTS + int'(seg_ff));
   assign rd_addr = {rd_row, term_ff};

   ctp_coef_store #(
      .SEGMENTS (SEGMENTS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_coefficient),
      .rd_addr (rd_addr),
      .rd_data (coef_q)
   );

   ctp_mac u_mac (
      .clock      (clock),
      .ctrl       (mac_ctrl),
      .coef       ($signed(coef_q)),
      .x          (x_lut[point_ff]),
      .add_result (mac_result)
   );

   // fire is due once elapsed time passes index * interval or the limit
   assign due      = CMP_W'(next_fire_ff) * CMP_W'(interval_ff);
   assign fire_due = (CMP_W'(elapsed_ff) > due) || (elapsed_ff > limit_ff);
   assign fire_inc = next_fire_ff + 1'b1;
   assign fire_ext = (FIRE_W + 4)'(next_fire_ff);

   always_comb begin
      mac_ctrl.load = (state_ff == ST_LOAD);
      mac_ctrl.mul  = (state_ff == ST_MUL);
      mac_ctrl.add  = (state_ff == ST_ADD);
   end

   always_comb begin
      state_in     = state_ff;
      playing_in   = playing_ff;
      elapsed_in   = elapsed_ff;
      next_fire_in = next_fire_ff;
      point_in     = point_ff;
      seg_in       = seg_ff;
      axis_in      = axis_ff;
      term_in      = term_ff;
      interval_in  = interval_ff;
      limit_in     = limit_ff;
      rsp_valid_in = 1'b0;
      roll_in      = roll_ff;
      pitch_in     = pitch_ff;
      yaw_in       = yaw_ff;
      fire_num_in  = fire_num_ff;
      last_in      = last_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FIRE_INTERVAL: interval_in = csr_data[INTERV_W-1:0];
            CSR_HYPERFRAME:    limit_in    = csr_data[LIMIT_W-1:0];
            default:           ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (func_type'(req_func))
                  FUNC_START: begin
                     elapsed_in   = '0;
                     next_fire_in = '0;
                     point_in     = '0;
                     seg_in       = '0;
                     playing_in   = 1'b1;
                  end
                  FUNC_TICK: begin
                     if (elapsed_ff != ELAPSED_MAX) begin
                        elapsed_in = elapsed_ff + 1'b1;
                     end
                     if (playing_ff) begin
                        state_in = ST_CHECK;
                     end
                  end
                  default: ;   // writes go straight to the table
               endcase
            end
         end
         ST_CHECK: begin
            if (fire_due) begin
               axis_in  = '0;
               term_in  = TERM_CUBE;
               state_in = ST_FETCH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            // cube word is on its way out of the RAM
            term_in  = TERM_SQUARE;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (term_ff == TERM_CONST) begin
               case (axis_ff)
                  2'd0:    roll_in  = mac_result;
                  2'd1:    pitch_in = mac_result;
                  default: yaw_in   = mac_result;
               endcase
               if (axis_ff == AXIS_COUNT - 2'd1) begin
                  // all three axes done: emit and step the fire position
                  rsp_valid_in = 1'b1;
                  fire_num_in  = fire_ext[3:0];
                  last_in      = (int'(fire_inc) >= TOTAL);
                  playing_in   = !(int'(fire_inc) >= TOTAL);
                  next_fire_in = fire_inc;
                  if (int'(point_ff) == POINTS - 1) begin
                     point_in = '0;
                     seg_in   = seg_ff + 1'b1;
                  end else begin
                     point_in = point_ff + 1'b1;
                  end
                  state_in = ST_IDLE;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  term_in  = TERM_CUBE;
                  state_in = ST_FETCH;
               end
            end else begin
               term_in  = term_ff - 1'b1;
               state_in = ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         playing_ff   <= 1'b0;
         elapsed_ff   <= '0;
         next_fire_ff <= '0;
         point_ff     <= '0;
         seg_ff       <= '0;
         axis_ff      <= '0;
         term_ff      <= '0;
         interval_ff  <= FIRE_INTERVAL_RESET;
         limit_ff     <= HYPERFRAME_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         playing_ff   <= playing_in;
         elapsed_ff   <= elapsed_in;
         next_fire_ff <= next_fire_in;
         point_ff     <= point_in;
         seg_ff       <= seg_in;
         axis_ff      <= axis_in;
         term_ff      <= term_in;
         interval_ff  <= interval_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      roll_ff     <= roll_in;
      pitch_ff    <= pitch_in;
      yaw_ff      <= yaw_in;
      fire_num_ff <= fire_num_in;
      last_ff     <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_roll_angle  = roll_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_yaw_angle   = yaw_ff;
   assign rsp_fire_number = fire_num_ff;
   assign rsp_last_fire   = last_ff;

endmodule

`default_nettype wire
